>>> rtl/xlf_pkg.sv
// xlf_pkg: types, operation kind codes and constants of the lazy flags unit
// no dependencies
`default_nettype none

package xlf_pkg;

  typedef enum logic [1:0] {
    ACT_RECORD = 2'd0,
    ACT_EVAL   = 2'd1,
    ACT_READ   = 2'd2,
    ACT_WRITE  = 2'd3
  } act_t;

  typedef enum logic [4:0] {
    K_ADD8     = 5'd0,
    K_ADD16    = 5'd1,
    K_ADD32    = 5'd2,
    K_ADC8     = 5'd3,
    K_ADC16    = 5'd4,
    K_ADC32    = 5'd5,
    K_SUB8     = 5'd6,
    K_SUB16    = 5'd7,
    K_SUB32    = 5'd8,
    K_SBB8     = 5'd9,
    K_SBB16    = 5'd10,
    K_SBB32    = 5'd11,
    K_LOGIC8   = 5'd12,
    K_LOGIC16  = 5'd13,
    K_LOGIC32  = 5'd14,
    K_SHL8     = 5'd15,
    K_SHL16    = 5'd16,
    K_SHL32    = 5'd17,
    K_SHR8     = 5'd18,
    K_SHR16    = 5'd19,
    K_SHR32    = 5'd20,
    K_MUL8     = 5'd21,
    K_MUL16    = 5'd22,
    K_MUL32    = 5'd23,
    K_RESTORED = 5'd24,
    K_DEC8     = 5'd25,
    K_DEC16    = 5'd26,
    K_DEC32    = 5'd27,
    K_INC8     = 5'd28,
    K_INC16    = 5'd29,
    K_INC32    = 5'd30
  } op_kind_t;

  typedef enum logic [2:0] {
    CT_O  = 3'd0,
    CT_B  = 3'd1,
    CT_Z  = 3'd2,
    CT_BE = 3'd3,
    CT_S  = 3'd4,
    CT_P  = 3'd5,
    CT_L  = 3'd6,
    CT_LE = 3'd7
  } cond_sel_t;

  localparam logic [31:0] FLAG_LOAD_MASK = 32'h0000_08d5;
  localparam int unsigned ZF_BIT = 6;
  localparam int unsigned DF_BIT = 10;

  typedef struct packed {
    act_t        action;
    logic [4:0]  op_kind;
    logic [31:0] result_value;
    logic [31:0] source_value;
    logic [3:0]  condition;
    logic        omit_cf_of;
    logic [31:0] write_bits;
    logic [31:0] write_mask;
  } xlf_item_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [31:0] result;
    logic [31:0] source;
    op_kind_t    saved_kind;
    logic [31:0] saved_result;
    logic        dflag;
    logic [31:0] other;
  } xlf_state_t;

  typedef struct packed {
    logic        en;
    act_t        action;
    logic [4:0]  kind;
    logic [31:0] result;
    logic [31:0] source;
    logic [31:0] bits;
    logic [31:0] mask;
  } xlf_upd_t;

endpackage

`default_nettype wire

>>> rtl/xlf_in_if.sv
// xlf_in_if: input channel of the lazy flags unit, valid/ready with item payload
// no dependencies
`default_nettype none

interface xlf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [4:0]  op_kind;
  logic [31:0] result_value;
  logic [31:0] source_value;
  logic [3:0]  condition;
  logic        omit_cf_of;
  logic [31:0] write_bits;
  logic [31:0] write_mask;

  modport source (
    output valid, action, op_kind, result_value, source_value, condition,
           omit_cf_of, write_bits, write_mask,
    input  ready
  );

  modport sink (
    input  valid, action, op_kind, result_value, source_value, condition,
           omit_cf_of, write_bits, write_mask,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/xlf_out_if.sv
// xlf_out_if: result channel of the lazy flags unit, valid/ready with result payload
// no dependencies
`default_nettype none

interface xlf_out_if;
  logic        valid;
  logic        ready;
  logic        cond_true;
  logic [31:0] flags_word;

  modport source (
    output valid, cond_true, flags_word,
    input  ready
  );

  modport sink (
    input  valid, cond_true, flags_word,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/xlf_state.sv
// xlf_state: lazy flag state registers and their update on record and write
// depends on xlf_pkg
`default_nettype none

module xlf_state
  import xlf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire xlf_upd_t   upd,
  output xlf_state_t      st
);

  xlf_state_t st_next;

  always_comb begin
    st_next = st;
    if (upd.en) begin
      unique case (upd.action)
        ACT_RECORD: begin
          if (upd.kind >= K_DEC8 && upd.kind <= K_INC32) begin
            if (st.kind < K_DEC8) begin
              st_next.saved_kind   = st.kind;
              st_next.saved_result = st.result;
            end
            st_next.kind   = op_kind_t'(upd.kind);
            st_next.result = upd.result;
          end else if (upd.kind < K_DEC8) begin
            st_next.kind   = op_kind_t'(upd.kind);
            st_next.result = upd.result;
            st_next.source = upd.source;
          end
        end
        ACT_WRITE: begin
          st_next.source = upd.bits & FLAG_LOAD_MASK;
          st_next.result = {31'd0, ~upd.bits[ZF_BIT]};
          st_next.kind   = K_RESTORED;
          st_next.dflag  = upd.bits[DF_BIT];
          st_next.other  = (st.other & ~upd.mask) | (upd.bits & upd.mask);
        end
        default: begin
          st_next = st;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{kind: K_ADD8, saved_kind: K_ADD8, default: '0};
    end else begin
      st <= st_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/xlf_eval.sv
// xlf_eval: works out condition outcome and flags word from the lazy state
// depends on xlf_pkg
`default_nettype none

module xlf_eval
  import xlf_pkg::*;
(
  input  wire xlf_state_t  st,
  input  wire act_t        action,
  input  wire logic [3:0]  condition,
  input  wire logic        omit_cf_of,
  output logic             cond_true,
  output logic [31:0]      flags_word
);

  logic [31:0] d, s, cd, sumc, sumc1, sum, sum1, dif, dif1;
  logic [31:0] t_add, t_adc, t_sub, t_sbb, x_ds;
  logic [4:0]  d5, s5, u5;
  op_kind_t    ck;
  logic        cf, pf, af, zf, sf, of, neg, be, lt, le, f;

  assign d     = st.result;
  assign s     = st.source;
  assign ck    = (st.kind >= K_DEC8) ? st.saved_kind : st.kind;
  assign cd    = (st.kind >= K_DEC8) ? st.saved_result : st.result;
  assign sumc  = cd + s;
  assign sumc1 = cd + s + 32'd1;
  assign sum   = d + s;
  assign sum1  = d + s + 32'd1;
  assign dif   = d - s;
  assign dif1  = d - s - 32'd1;
  assign t_add = (dif ^ ~s) & (dif ^ d);
  assign t_adc = (dif1 ^ ~s) & (dif1 ^ d);
  assign t_sub = (sum ^ s) & (sum ^ d);
  assign t_sbb = (sum1 ^ s) & (sum1 ^ d);
  assign x_ds  = s ^ d;
  assign d5    = d[4:0];
  assign s5    = s[4:0];
  assign zf    = (d == 32'd0);
  assign neg   = d[31];
  assign pf    = (st.kind == K_RESTORED) ? s[2] : ~^d[7:0];
  assign sf    = (st.kind == K_RESTORED) ? s[7] : d[31];

  // carry, from the saved operation for inc/dec
  always_comb begin
    case (ck) inside
      K_ADD8:                      cf = cd[7:0] < s[7:0];
      K_ADD16:                     cf = cd[15:0] < s[15:0];
      K_ADD32:                     cf = cd < s;
      K_ADC8:                      cf = cd[7:0] <= s[7:0];
      K_ADC16:                     cf = cd[15:0] <= s[15:0];
      K_ADC32:                     cf = cd <= s;
      K_SUB8:                      cf = sumc[7:0] < s[7:0];
      K_SUB16:                     cf = sumc[15:0] < s[15:0];
      K_SUB32:                     cf = sumc < s;
      K_SBB8:                      cf = sumc1[7:0] <= s[7:0];
      K_SBB16:                     cf = sumc1[15:0] <= s[15:0];
      K_SBB32:                     cf = sumc1 <= s;
      K_SHL8:                      cf = s[7];
      K_SHL16:                     cf = s[15];
      K_SHL32:                     cf = s[31];
      K_SHR8, K_SHR16, K_SHR32,
      K_RESTORED:                  cf = s[0];
      K_MUL8, K_MUL16, K_MUL32:    cf = (s != 32'd0);
      default:                     cf = 1'b0;
    endcase
  end

  // auxiliary carry, only bit 4 matters
  always_comb begin
    u5 = 5'd0;
    af = 1'b0;
    case (st.kind) inside
      K_ADD8, K_ADD16, K_ADD32: begin
        u5 = d5 - s5;
        af = (d5[4] ^ u5[4] ^ s5[4]);
      end
      K_ADC8, K_ADC16, K_ADC32: begin
        u5 = d5 - s5 - 5'd1;
        af = (d5[4] ^ u5[4] ^ s5[4]);
      end
      K_SUB8, K_SUB16, K_SUB32: begin
        u5 = d5 + s5;
        af = (d5[4] ^ u5[4] ^ s5[4]);
      end
      K_SBB8, K_SBB16, K_SBB32: begin
        u5 = d5 + s5 + 5'd1;
        af = (d5[4] ^ u5[4] ^ s5[4]);
      end
      K_RESTORED: af = s[4];
      K_DEC8, K_DEC16, K_DEC32: begin
        u5 = d5 - 5'd1;
        af = d5[4] ^ u5[4];
      end
      K_INC8, K_INC16, K_INC32: begin
        u5 = d5 + 5'd1;
        af = d5[4] ^ u5[4];
      end
      default: af = 1'b0;
    endcase
  end

  // overflow
  always_comb begin
    case (st.kind) inside
      K_ADD8:               of = t_add[7];
      K_ADD16:              of = t_add[15];
      K_ADD32:              of = t_add[31];
      K_ADC8:               of = t_adc[7];
      K_ADC16:              of = t_adc[15];
      K_ADC32:              of = t_adc[31];
      K_SUB8:               of = t_sub[7];
      K_SUB16:              of = t_sub[15];
      K_SUB32:              of = t_sub[31];
      K_SBB8:               of = t_sbb[7];
      K_SBB16:              of = t_sbb[15];
      K_SBB32:              of = t_sbb[31];
      K_SHL8, K_SHR8:       of = x_ds[7];
      K_SHL16, K_SHR16:     of = x_ds[15];
      K_SHL32, K_SHR32:     of = x_ds[31];
      K_MUL8, K_MUL16,
      K_MUL32:              of = (s != 32'd0);
      K_RESTORED:           of = s[11];
      K_DEC8:               of = (d[7:0] == 8'h80);
      K_DEC16:              of = (d[15:0] == 16'h8000);
      K_DEC32:              of = (d == 32'h8000_0000);
      K_INC8:               of = (d[7:0] == 8'h7f);
      K_INC16:              of = (d[15:0] == 16'h7fff);
      K_INC32:              of = (d == 32'h7fff_ffff);
      default:              of = 1'b0;
    endcase
  end

  // below-or-equal and signed compares
  always_comb begin
    case (st.kind) inside
      K_SUB8:     be = sum[7:0] <= s[7:0];
      K_SUB16:    be = sum[15:0] <= s[15:0];
      K_SUB32:    be = sum <= s;
      K_RESTORED: be = s[6] | s[0];
      default:    be = cf | zf;
    endcase
  end

  always_comb begin
    case (st.kind) inside
      K_SUB8: begin
        lt = $signed(sum[7:0]) < $signed(s[7:0]);
        le = lt | (sum[7:0] == s[7:0]);
      end
      K_SUB16: begin
        lt = $signed(sum[15:0]) < $signed(s[15:0]);
        le = lt | (sum[15:0] == s[15:0]);
      end
      K_SUB32: begin
        lt = $signed(sum) < $signed(s);
        le = lt | (sum == s);
      end
      K_LOGIC8, K_LOGIC16, K_LOGIC32, K_DEC8, K_DEC16, K_DEC32,
      K_INC8, K_INC16, K_INC32: begin
        lt = neg;
        le = neg | zf;
      end
      K_RESTORED: begin
        lt = s[7] ^ s[11];
        le = lt | s[6];
      end
      default: begin
        lt = neg ^ of;
        le = lt | zf;
      end
    endcase
  end

  always_comb begin
    unique case (cond_sel_t'(condition[3:1]))
      CT_O:  f = of;
      CT_B:  f = cf;
      CT_Z:  f = zf;
      CT_BE: f = be;
      CT_S:  f = sf;
      CT_P:  f = pf;
      CT_L:  f = lt;
      CT_LE: f = le;
      default: f = 1'b0;
    endcase
  end

  assign cond_true  = (action == ACT_EVAL) ? (f ^ condition[0]) : 1'b0;
  assign flags_word = (action == ACT_READ)
                    ? (st.other | {20'd0, of & ~omit_cf_of, st.dflag, 2'b00, sf, zf,
                                   1'b0, af, 1'b0, pf, 1'b0, cf & ~omit_cf_of})
                    : 32'd0;

endmodule

`default_nettype wire

>>> rtl/x86_lazy_flags_unit_top.sv
// x86_lazy_flags_unit_top: input register, flag evaluation, state and result register
// depends on xlf_pkg, xlf_in_if, xlf_out_if, xlf_state, xlf_eval
`default_nettype none

// Lazy x86 flags unit. Every transfer on req gives exactly one transfer on rsp,
// after passing through the input register, where the flags are evaluated from
// the stored operation, and then the result register. One item is taken every
// cycle while rsp is not stalled; the stored operation is updated as an item
// leaves the input register, so the next item already sees it.
module x86_lazy_flags_unit_top
  import xlf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  xlf_in_if.sink       req,
  xlf_out_if.source    rsp
);

  logic        s1_valid;
  xlf_item_t   s1;
  logic        adv;
  logic        rsp_valid;
  logic        rsp_cond;
  logic [31:0] rsp_flags;
  xlf_state_t  st;
  xlf_upd_t    upd;
  logic        ct;
  logic [31:0] fw;

  assign adv       = s1_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !s1_valid || !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1.action       <= act_t'(req.action);
      s1.op_kind      <= req.op_kind;
      s1.result_value <= req.result_value;
      s1.source_value <= req.source_value;
      s1.condition    <= req.condition;
      s1.omit_cf_of   <= req.omit_cf_of;
      s1.write_bits   <= req.write_bits;
      s1.write_mask   <= req.write_mask;
    end
  end

  assign upd.en     = adv;
  assign upd.action = s1.action;
  assign upd.kind   = s1.op_kind;
  assign upd.result = s1.result_value;
  assign upd.source = s1.source_value;
  assign upd.bits   = s1.write_bits;
  assign upd.mask   = s1.write_mask;

  xlf_state u_state (
    .clk (clk),
    .rst (rst),
    .upd (upd),
    .st  (st)
  );

  xlf_eval u_eval (
    .st         (st),
    .action     (s1.action),
    .condition  (s1.condition),
    .omit_cf_of (s1.omit_cf_of),
    .cond_true  (ct),
    .flags_word (fw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!rsp_valid || rsp.ready) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp_cond  <= ct;
      rsp_flags <= fw;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.cond_true  = rsp_cond;
  assign rsp.flags_word = rsp_flags;

`ifndef SYNTHESIS
  // the saved operation for carry is never an inc/dec kind
  a_saved_kind: assert property (@(posedge clk) disable iff (rst)
    st.saved_kind < K_DEC8)
    else $error("saved kind is inc/dec");

  // direction flag only moves on a flags write
  a_dflag: assert property (@(posedge clk) disable iff (rst)
    !(adv && s1.action == ACT_WRITE) |=> $stable(st.dflag))
    else $error("direction flag changed without write");

  // a result carries at most one kind of answer
  a_one_answer: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_cond && rsp_flags != 32'd0))
    else $error("both condition and flags word set");

  // an item in the input register waits while the result register is stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(s1))
    else $error("input register lost an item");
`endif

endmodule

`default_nettype wire
